// ----- rtl/ceb_pkg.sv -----
// Shared types, constants and the cosine ROM generator for the eased ARGB blend.
// Used by ceb_front, ceb_queue, ceb_back and eased_argb_color_blend.
// No dependencies.
package ceb_pkg;

  localparam int FracBits        = 16;
  localparam int TableEntriesDef = 256;
  localparam int QueueDepth      = 8;
  localparam int FrontStages     = 4;
  localparam int RomShift        = 60 - FracBits;

  localparam int CntW  = $clog2(QueueDepth + 1);
  localparam int PtrW  = $clog2(QueueDepth);
  localparam int BusyW = $clog2(FrontStages + 1);
  localparam int UsedW = $clog2(QueueDepth + FrontStages + 1);

  localparam logic [FracBits:0] OneFx = {1'b1, {FracBits{1'b0}}};
  localparam logic [63:0]       Q60Pi = 64'h3243F6A8885A308D;

  typedef enum logic [1:0] {
    ModeLinear   = 2'd0,
    ModeSmooth   = 2'd1,
    ModeSmoother = 2'd2,
    ModeCosine   = 2'd3
  } ceb_mode_e;

  // per-item class picked at accept; ClsOne covers a saturated factor in any mode
  typedef enum logic [2:0] {
    ClsLinear   = 3'd0,
    ClsSmooth   = 3'd1,
    ClsSmoother = 3'd2,
    ClsCosine   = 3'd3,
    ClsOne      = 3'd4
  } ceb_cls_e;

  typedef struct packed {
    logic [31:0]       color_from;
    logic [31:0]       color_to;
    logic [FracBits:0] factor;
  } ceb_item_t;

  typedef struct packed {
    logic      valid;
    ceb_item_t item;
  } ceb_push_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            empty;
  } ceb_qstat_t;

  typedef struct packed {
    logic [BusyW-1:0] busy;
  } ceb_fstat_t;

  // ---- elaboration-time helpers for the cosine ROM (Q.60 fixed point) ----

  function automatic logic [63:0] mul_shr60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // restoring shift-subtract division
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // (1 - cos(theta)) / 2 by Taylor series, theta in [0, pi/2]
  function automatic logic [63:0] half_versine(input logic [63:0] theta);
    logic [63:0]        th2;
    logic [63:0]        term;
    logic [63:0]        den;
    logic signed [63:0] sum;
    th2  = mul_shr60(theta, theta);
    term = th2 >> 1;
    sum  = '0;
    for (int k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        if ((k & 1) == 1) sum = sum + $signed(term);
        else              sum = sum - $signed(term);
        den  = 64'((2 * k + 1) * (2 * k + 2));
        term = udiv64(mul_shr60(term, th2), den);
      end
    end
    if (sum < 0) sum = '0;
    return $unsigned(sum) >> 1;
  endfunction

  // ROM entry idx of n: lower half from the series, upper half mirrored
  function automatic logic [FracBits:0] cos_entry(input int idx, input int n);
    logic [63:0] step;
    logic [63:0] rem;
    logic [63:0] theta;
    logic [63:0] v;
    logic [63:0] nn;
    logic [63:0] ii;
    int          j;
    j     = (2 * idx <= n) ? idx : n - idx;
    nn    = 64'(n);
    ii    = 64'(j);
    step  = udiv64(Q60Pi, nn);
    rem   = Q60Pi - step * nn;
    theta = step * ii + udiv64(rem * ii, nn);
    v     = half_versine(theta);
    v     = (v + (64'd1 << (RomShift - 1))) >> RomShift;
    if (2 * idx <= n) return v[FracBits:0];
    return OneFx - v[FracBits:0];
  endfunction

endpackage

// ----- rtl/ceb_front.sv -----
// Front end: accepts items, classifies them by easing mode and computes the eased
// factor in a fixed four-stage pipeline with no internal stall. Holds the cosine ROM.
// Depends on ceb_pkg.
module ceb_front #(
  parameter int TableEntries = ceb_pkg::TableEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ceb_pkg::ceb_mode_e        mode_i,
  input  logic                      accept_i,
  input  logic [31:0]               color_from_i,
  input  logic [31:0]               color_to_i,
  input  logic [ceb_pkg::FracBits:0] blend_factor_i,
  output ceb_pkg::ceb_push_t        push_o,
  output ceb_pkg::ceb_fstat_t       stat_o
);
  import ceb_pkg::*;

  localparam int AW = $clog2(TableEntries + 1);
  localparam logic [FracBits-1:0] TabN     = FracBits'(TableEntries);
  localparam logic [FracBits+1:0] ThreeOne = (FracBits + 2)'(3) << FracBits;

  // cosine ROM, fixed at elaboration
  logic [FracBits:0] rom [0:TableEntries];
  for (genvar gi = 0; gi <= TableEntries; gi++) begin : g_rom
    localparam logic [FracBits:0] RomVal = cos_entry(gi, TableEntries);
    assign rom[gi] = RomVal;
  end

  logic [FrontStages-1:0] vld_q;

  // stage 1: accepted item
  ceb_cls_e              cls_d;
  ceb_cls_e              s1_cls_q, s2_cls_q, s3_cls_q, s4_cls_q;
  logic [31:0]           s1_c1_q, s2_c1_q, s3_c1_q, s4_c1_q;
  logic [31:0]           s1_c2_q, s2_c2_q, s3_c2_q, s4_c2_q;
  logic [FracBits-1:0]   s1_t_q, s2_t_q, s3_t_q;

  // stage 2: t^2 or t*N
  logic [FracBits-1:0]   mul2_b;
  logic [2*FracBits-1:0] m2_d, m2_q;

  // stage 3
  logic [FracBits+1:0]   mul3_b;
  logic [49:0]           m3_d, m3_q;
  logic [36:0]           p_full;
  logic [35:0]           p3_q;
  logic [AW-1:0]         idx_lo, idx_hi;
  logic [FracBits:0]     rom_lo_q, rom_hi_q;
  logic [FracBits-1:0]   frac3_q;

  // stage 4
  logic [FracBits:0]     diff;
  logic [31:0]           mul4_a;
  logic [35:0]           mul4_b;
  logic [67:0]           m4a_d, m4a_q;
  logic [51:0]           m4b_d, m4b_q;
  logic [FracBits:0]     e4_d, e4_q;
  logic [FracBits:0]     lo4_q;

  // output of stage 4
  logic [83:0]           sum84;
  logic [FracBits+1:0]   e_raw;
  logic [FracBits:0]     e_out;

  always_comb begin
    if (blend_factor_i >= OneFx) begin
      cls_d = ClsOne;
    end else begin
      case (mode_i)
        ModeSmooth:   cls_d = ClsSmooth;
        ModeSmoother: cls_d = ClsSmoother;
        ModeCosine:   cls_d = ClsCosine;
        default:      cls_d = ClsLinear;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontStages-2:0], accept_i};
    end
  end

  // stage 2 multiplier is shared: t*t for the polynomials, t*N for cosine
  assign mul2_b = (s1_cls_q == ClsCosine) ? TabN : s1_t_q;
  assign m2_d   = s1_t_q * mul2_b;

  // stage 3: t^2*(3-2t) or t^3; smootherstep polynomial 6t^2 - 15t + 10
  assign mul3_b = (s2_cls_q == ClsSmooth) ? (ThreeOne - {1'b0, s2_t_q, 1'b0})
                                          : {2'b00, s2_t_q};
  assign m3_d   = m2_q * mul3_b;
  assign p_full = ({5'd0, m2_q} << 2) + ({5'd0, m2_q} << 1)
                + (37'd10 << (2 * FracBits))
                - ((37'(s2_t_q) << (FracBits + 4)) - (37'(s2_t_q) << FracBits));
  assign idx_lo = m2_q[FracBits +: AW];
  assign idx_hi = idx_lo + 1'b1;

  // stage 4: t^3*p as two partial products, or ROM slope times fraction
  assign diff   = (rom_hi_q < rom_lo_q) ? '0 : rom_hi_q - rom_lo_q;
  assign mul4_a = (s3_cls_q == ClsCosine) ? 32'(diff) : m3_q[31:0];
  assign mul4_b = (s3_cls_q == ClsCosine) ? 36'(frac3_q) : p3_q;
  assign m4a_d  = mul4_a * mul4_b;
  assign m4b_d  = m3_q[47:32] * p3_q;

  always_comb begin
    case (s3_cls_q)
      ClsLinear: e4_d = {1'b0, s3_t_q};
      ClsSmooth: e4_d = m3_q[2*FracBits +: FracBits+1];
      ClsOne:    e4_d = OneFx;
      default:   e4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_cls_q <= cls_d;
    s1_c1_q  <= color_from_i;
    s1_c2_q  <= color_to_i;
    s1_t_q   <= blend_factor_i[FracBits-1:0];

    s2_cls_q <= s1_cls_q;
    s2_c1_q  <= s1_c1_q;
    s2_c2_q  <= s1_c2_q;
    s2_t_q   <= s1_t_q;
    m2_q     <= m2_d;

    s3_cls_q <= s2_cls_q;
    s3_c1_q  <= s2_c1_q;
    s3_c2_q  <= s2_c2_q;
    s3_t_q   <= s2_t_q;
    m3_q     <= m3_d;
    p3_q     <= p_full[35:0];
    rom_lo_q <= rom[idx_lo];
    rom_hi_q <= rom[idx_hi];
    frac3_q  <= m2_q[FracBits-1:0];

    s4_cls_q <= s3_cls_q;
    s4_c1_q  <= s3_c1_q;
    s4_c2_q  <= s3_c2_q;
    m4a_q    <= m4a_d;
    m4b_q    <= m4b_d;
    e4_q     <= e4_d;
    lo4_q    <= rom_lo_q;
  end

  assign sum84 = {16'd0, m4a_q} + {m4b_q, 32'd0};

  always_comb begin
    case (s4_cls_q)
      ClsSmoother: e_raw = {1'b0, sum84[4*FracBits +: FracBits+1]};
      ClsCosine:   e_raw = {1'b0, lo4_q} + {1'b0, m4a_q[FracBits +: FracBits+1]};
      default:     e_raw = {1'b0, e4_q};
    endcase
  end

  assign e_out = (e_raw > {1'b0, OneFx}) ? OneFx : e_raw[FracBits:0];

  assign push_o.valid           = vld_q[FrontStages-1];
  assign push_o.item.color_from = s4_c1_q;
  assign push_o.item.color_to   = s4_c2_q;
  assign push_o.item.factor     = e_out;
  assign stat_o.busy            = BusyW'($countones(vld_q));

endmodule

// ----- rtl/ceb_queue.sv -----
// Short FIFO between the easing front end and the blend back end.
// Register based; the caller never pushes into a full queue. Depends on ceb_pkg.
module ceb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ceb_pkg::ceb_push_t  push_i,
  input  logic                pop_i,
  output ceb_pkg::ceb_item_t  head_o,
  output ceb_pkg::ceb_qstat_t stat_o
);
  import ceb_pkg::*;

  ceb_item_t       mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_ptr_q] <= push_i.item;
    end
  end

  assign head_o       = mem[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

// ----- rtl/ceb_back.sv -----
// Back end: pops an eased item from the queue, blends the four ARGB channels with
// round half up, and holds the result in the output register. Depends on ceb_pkg.
module ceb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ceb_pkg::ceb_item_t  head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         color_out_o
);
  import ceb_pkg::*;

  localparam logic signed [FracBits+10:0] Half = (FracBits + 11)'(1) << (FracBits - 1);

  logic        valid_q, valid_d;
  logic [31:0] color_q;
  logic [31:0] blend;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0]                 a;
    logic [7:0]                 b;
    logic signed [8:0]          diff;
    logic signed [FracBits+10:0] prod;
    logic signed [FracBits+10:0] num;
    assign a    = head_i.color_from[8*l +: 8];
    assign b    = head_i.color_to[8*l +: 8];
    assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
    assign prod = $signed({1'b0, head_i.factor}) * diff;
    // convex combination, so the sum stays in 0 .. 255.5 and never goes negative
    assign num  = $signed({3'b000, a, {FracBits{1'b0}}}) + prod + Half;
    assign blend[8*l +: 8] = num[FracBits +: 8];
  end

  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      color_q <= blend;
    end
  end

  assign out_valid_o = valid_q;
  assign color_out_o = color_q;

endmodule

// ----- rtl/eased_argb_color_blend.sv -----
// Top level of the eased ARGB colour blend: config register, stall credit logic,
// and the front end / queue / back end chain. Depends on ceb_pkg, ceb_front,
// ceb_queue and ceb_back.
//
// Usage:
//   Input channel: color_from_i, color_to_i, blend_factor_i (Q1.16, saturates at
//   1.0) transfer when in_valid_i is high and in_stall_o is low. Output channel:
//   color_out_o transfers when out_valid_o is high and out_stall_i is low.
//   Config channel: cfg_easing_mode_i is written when cfg_valid_i and cfg_ready_o
//   are high; cfg_ready_o is always high. Write it only while the block is idle.
//   An input transfer passes through the 4 easing stages, one queue slot and the
//   output register to out_valid_o. Throughput: one item per cycle while
//   out_stall_i is low. The 8-entry queue sets the credit: in_stall_o rises once
//   the items in the easing pipeline plus those in the queue reach 8, and the
//   pipeline itself never stalls.
//   When the receiver stalls, results back up in the queue and the input stalls
//   once that credit runs out; nothing is dropped.
//   Reset clears all valid state and sets the easing mode to linear; the cosine
//   ROM is constant and needs no clearing pass.
module eased_argb_color_blend #(
  parameter int TableEntries = ceb_pkg::TableEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_easing_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [31:0]                color_from_i,
  input  logic [31:0]                color_to_i,
  input  logic [ceb_pkg::FracBits:0] blend_factor_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                color_out_o
);
  import ceb_pkg::*;

  ceb_mode_e        mode_q;
  logic             accept;
  logic [UsedW-1:0] used;
  ceb_push_t        push;
  ceb_fstat_t       f_stat;
  ceb_qstat_t       q_stat;
  ceb_item_t        head;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLinear;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= ceb_mode_e'(cfg_easing_mode_i);
    end
  end

  // every item in flight holds a queue slot from transfer until it is popped
  assign used       = UsedW'(q_stat.count) + UsedW'(f_stat.busy);
  assign in_stall_o = (used >= UsedW'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;

  ceb_front #(
    .TableEntries(TableEntries)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .accept_i      (accept),
    .color_from_i  (color_from_i),
    .color_to_i    (color_to_i),
    .blend_factor_i(blend_factor_i),
    .push_o        (push),
    .stat_o        (f_stat)
  );

  ceb_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  ceb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_stat.empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .color_out_o(color_out_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= UsedW'(QueueDepth))
    else $error("queue credit exceeded");

  a_front_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 push.valid)
    else $error("accepted item did not reach the queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.count == '0) |-> !pop)
    else $error("pop from empty queue");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("popped item not presented");

endmodule
